// File: hw/rtl/mlp_pkg.sv
// Package: shared types, constants and the sigmoid table for the MLP block.
`default_nettype none
package mlp_pkg;

  localparam int unsigned MaxInputs    = 64;
  localparam int unsigned MaxLayerSize = 32;
  localparam int unsigned MaxLayers    = 4;
  localparam int unsigned WeightDepth  = 4096;
  localparam int unsigned SizeRegs     = 4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] RegNumInputs  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNumLayers  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLayerSize0 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLayerSize1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLayerSize2 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLayerSize3 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegActMode    = 3'd6;

  localparam logic ActWeight = 1'b0;
  localparam logic ActSample = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] weight_index;
    logic [5:0]  sample_index;
    logic signed [15:0] value;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  neuron_index;
    logic signed [15:0] activation;
    logic        last_output;
  } out_item_t;

  typedef struct packed {
    logic [6:0] num_inputs;
    logic [2:0] num_layers;
    logic [5:0] layer_size_0;
    logic [5:0] layer_size_1;
    logic [5:0] layer_size_2;
    logic [5:0] layer_size_3;
    logic       activation_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    EngIdle,
    EngSetup,
    EngMac,
    EngDrain,
    EngFinish,
    EngEmit
  } eng_state_e;

  // Sigmoid table: entry i = sigmoid((i-128)/16) in Q4.12, packed 16 bits per entry.
  function automatic logic [4095:0] sigmoid_table_init();
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] v;
    logic [4095:0] t;
    int k;
    int b;
    t = '0;
    e = 64'd1 << 32;
    t[128*16 +: 16] = 16'd2048;
    for (k = 1; k <= 128; k++) begin
      e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
      d = (64'd1 << 32) + e;
      n = 64'd4096 * e + (d >> 1);
      // rounded quotient fits in 13 bits: restoring steps
      v = '0;
      for (b = 12; b >= 0; b--) begin
        if (n >= (d << b)) begin
          n = n - (d << b);
          v = v | (64'd1 << b);
        end
      end
      t[(128-k)*16 +: 16] = v[15:0];
      if (k < 128) t[(128+k)*16 +: 16] = 16'd4096 - v[15:0];
    end
    return t;
  endfunction

  localparam logic [4095:0] SigmoidTable = sigmoid_table_init();

  function automatic logic [15:0] sigmoid_lut(input logic [7:0] idx);
    return SigmoidTable[{idx, 4'd0} +: 16];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mlp_if.sv
// Interfaces: valid/ready item channels and the configuration write channel.
`default_nettype none
interface mlp_in_if;
  logic valid;
  logic ready;
  mlp_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mlp_out_if;
  logic valid;
  logic ready;
  mlp_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mlp_cfg_if;
  logic valid;
  logic ready;
  logic [mlp_pkg::CfgIdxW-1:0]  index;
  logic [mlp_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mlp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module mlp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/mlp_front.sv
// Front end: accepts items, writes weights and samples, queues evaluation starts.
`default_nettype none
module mlp_front #(
  parameter int unsigned MaxInputs   = mlp_pkg::MaxInputs,
  parameter int unsigned WeightDepth = mlp_pkg::WeightDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mlp_in_if.sink    in_if,
  output logic      w_we_o,
  output logic [$clog2(WeightDepth)-1:0] w_waddr_o,
  output logic      x_we_o,
  output logic [$clog2(MaxInputs)-1:0] x_waddr_o,
  output logic [15:0] wdata_o,
  output logic      start_o,
  input  wire logic start_take_i
);
  localparam int unsigned WaW = $clog2(WeightDepth);
  localparam int unsigned XaW = $clog2(MaxInputs);

  // one-deep start queue; new items wait while an evaluation is pending
  logic pend_q, pend_d;
  logic acc;

  assign in_if.ready = !pend_q;
  assign acc = in_if.valid && in_if.ready;

  always_comb begin
    w_we_o = acc && (in_if.payload.action == mlp_pkg::ActWeight) &&
             (32'(in_if.payload.weight_index) < WeightDepth);
    x_we_o = acc && (in_if.payload.action == mlp_pkg::ActSample) &&
             (32'(in_if.payload.sample_index) < MaxInputs);
    w_waddr_o = WaW'(in_if.payload.weight_index);
    x_waddr_o = XaW'(in_if.payload.sample_index);
    wdata_o = in_if.payload.value;
    pend_d = pend_q;
    if (start_take_i) begin
      pend_d = 1'b0;
    end
    if (acc && in_if.payload.action == mlp_pkg::ActSample && in_if.payload.last_sample) begin
      pend_d = 1'b1;
    end
  end

  assign start_o = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/mlp_engine.sv
// Back end: layer-by-layer MAC walk, activation, and result emission.
`default_nettype none
module mlp_engine #(
  parameter int unsigned MaxInputs    = mlp_pkg::MaxInputs,
  parameter int unsigned MaxLayerSize = mlp_pkg::MaxLayerSize,
  parameter int unsigned MaxLayers    = mlp_pkg::MaxLayers,
  parameter int unsigned WeightDepth  = mlp_pkg::WeightDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  mlp_pkg::cfg_t cfg_i,
  input  wire logic start_i,
  output logic      start_take_o,
  output logic [$clog2(WeightDepth)-1:0] w_raddr_o,
  input  wire logic [15:0] w_rdata_i,
  output logic [$clog2(MaxInputs)-1:0] x_raddr_o,
  input  wire logic [15:0] x_rdata_i,
  mlp_out_if.source out_if
);
  localparam int unsigned WaW = $clog2(WeightDepth);
  localparam int unsigned XaW = $clog2(MaxInputs);
  localparam int unsigned LsW = $clog2(MaxLayerSize);
  localparam int unsigned NiW = $clog2(MaxInputs + 1);
  localparam int unsigned SzW = $clog2(MaxLayerSize + 1);
  localparam int unsigned LyW = $clog2(MaxLayers + 1);
  localparam int unsigned PrW = (NiW > SzW) ? NiW : SzW;
  localparam int unsigned SizeLimit = (MaxLayerSize < 32) ? MaxLayerSize : 32;
  localparam int unsigned LayerLimit =
      (MaxLayers < mlp_pkg::SizeRegs) ? MaxLayers : mlp_pkg::SizeRegs;
  localparam int unsigned AccW = 32 + PrW;

  mlp_pkg::eng_state_e state_q, state_d;

  logic [LyW-1:0] layer_q, layer_d, nlay_q, nlay_d;
  logic [PrW-1:0] prev_q, prev_d;
  logic [SzW-1:0] size_q, size_d;
  logic [SzW-1:0] n_q, n_d;
  logic [PrW-1:0] j_q, j_d;
  logic [WaW-1:0] base_q, base_d;   // weight row base (wraps)
  logic [WaW-1:0] rd_q, rd_d;
  logic           src_in_q, src_in_d; // source is input vector
  logic           bsel_q, bsel_d;     // destination buffer b
  logic           v1_q, v2_q, v2_d;   // read / product pipeline valids
  logic signed [31:0] prod_q;
  logic signed [AccW-1:0] acc_q, acc_d;

  logic [15:0] buf_a_q [MaxLayerSize];
  logic [15:0] buf_b_q [MaxLayerSize];
  logic [15:0] bsrc_q;
  logic [5:0]  raw_sz;
  logic [SzW-1:0] cl_sz;
  logic [6:0]  raw_ni;
  logic [PrW-1:0] cl_ni;
  logic [LyW-1:0] cl_nl;
  logic issue;
  logic [15:0] xval;
  logic signed [AccW-1:0] q_sh;
  logic signed [15:0] sat;
  logic [15:0] actv;
  logic        ov_v_q, ov_v_d;
  mlp_pkg::out_item_t ov_q, ov_d;

  always_comb begin
    case (layer_d[1:0])
      2'd0: raw_sz = cfg_i.layer_size_0;
      2'd1: raw_sz = cfg_i.layer_size_1;
      2'd2: raw_sz = cfg_i.layer_size_2;
      default: raw_sz = cfg_i.layer_size_3;
    endcase
    if (raw_sz == 6'd0) cl_sz = SzW'(1);
    else if (32'(raw_sz) > SizeLimit) cl_sz = SzW'(SizeLimit);
    else cl_sz = SzW'(raw_sz);
    raw_ni = cfg_i.num_inputs;
    if (raw_ni == 7'd0) cl_ni = PrW'(1);
    else if (32'(raw_ni) > MaxInputs) cl_ni = PrW'(MaxInputs);
    else cl_ni = PrW'(raw_ni);
    if (cfg_i.num_layers == 3'd0) cl_nl = LyW'(1);
    else if (32'(cfg_i.num_layers) > LayerLimit) cl_nl = LyW'(LayerLimit);
    else cl_nl = LyW'(cfg_i.num_layers);
  end

  assign issue = (state_q == mlp_pkg::EngMac);
  assign w_raddr_o = rd_q;
  assign x_raddr_o = XaW'(j_q);
  assign xval = src_in_q ? x_rdata_i : bsrc_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlp_pkg::EngIdle:   if (start_i) state_d = mlp_pkg::EngSetup;
      mlp_pkg::EngSetup:  state_d = mlp_pkg::EngMac;
      mlp_pkg::EngMac:    if (j_q == prev_q - PrW'(1)) state_d = mlp_pkg::EngDrain;
      mlp_pkg::EngDrain:  if (!v1_q && !v2_q) state_d = mlp_pkg::EngFinish;
      mlp_pkg::EngFinish: begin
        if (n_q != size_q - SzW'(1)) state_d = mlp_pkg::EngMac;
        else if (layer_q != nlay_q - LyW'(1)) state_d = mlp_pkg::EngSetup;
        else state_d = mlp_pkg::EngEmit;
      end
      mlp_pkg::EngEmit: begin
        if ((!ov_v_q || out_if.ready) && n_q == size_q - SzW'(1)) state_d = mlp_pkg::EngIdle;
      end
      default: state_d = mlp_pkg::EngIdle;
    endcase
  end

  // datapath control
  always_comb begin
    layer_d = layer_q; nlay_d = nlay_q; prev_d = prev_q; size_d = size_q;
    n_d = n_q; j_d = j_q; base_d = base_q; rd_d = rd_q;
    src_in_d = src_in_q; bsel_d = bsel_q; acc_d = acc_q;
    v2_d = v1_q;
    start_take_o = 1'b0;
    ov_v_d = ov_v_q; ov_d = ov_q;
    if (ov_v_q && out_if.ready) ov_v_d = 1'b0;
    if (v2_q) acc_d = acc_q + AccW'(prod_q);
    case (state_q)
      mlp_pkg::EngIdle: begin
        if (start_i) begin
          layer_d = '0; nlay_d = cl_nl; prev_d = cl_ni;
          base_d = '0; src_in_d = 1'b1; bsel_d = 1'b0;
        end
      end
      mlp_pkg::EngSetup: begin
        size_d = cl_sz; n_d = '0; j_d = '0; rd_d = base_q; acc_d = '0;
      end
      mlp_pkg::EngMac: begin
        j_d = j_q + PrW'(1);
        rd_d = rd_q + WaW'(1);
      end
      mlp_pkg::EngFinish: begin
        base_d = rd_q;
        j_d = '0; acc_d = '0;
        if (n_q != size_q - SzW'(1)) begin
          n_d = n_q + SzW'(1);
        end else if (layer_q != nlay_q - LyW'(1)) begin
          layer_d = layer_q + LyW'(1);
          prev_d = PrW'(size_q);
          src_in_d = 1'b0;
          bsel_d = ~bsel_q;
        end else begin
          n_d = '0;
        end
      end
      mlp_pkg::EngEmit: begin
        if (!ov_v_q || out_if.ready) begin
          ov_v_d = 1'b1;
          ov_d.neuron_index = 5'(n_q);
          ov_d.activation = bsel_q ? buf_b_q[LsW'(n_q)] : buf_a_q[LsW'(n_q)];
          ov_d.last_output = (n_q == size_q - SzW'(1));
          n_d = n_q + SzW'(1);
          // memories are free once the last beat is loaded
          start_take_o = (n_q == size_q - SzW'(1));
        end
      end
      default: ;
    endcase
  end

  // floor shift and saturate, then activate
  always_comb begin
    q_sh = acc_q >>> 12;
    if (q_sh > AccW'(32767)) sat = 16'sd32767;
    else if (q_sh < -AccW'(32768)) sat = -16'sd32768;
    else sat = q_sh[15:0];
    if (cfg_i.activation_mode) actv = (sat <= 0) ? 16'd0 : sat;
    else actv = mlp_pkg::sigmoid_lut(sat[15:8] ^ 8'h80);
  end

  assign out_if.valid = ov_v_q;
  assign out_if.payload = ov_q;

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(w_rdata_i) * $signed(xval);
    bsrc_q <= bsel_q ? buf_a_q[LsW'(j_q)] : buf_b_q[LsW'(j_q)];
    if (state_q == mlp_pkg::EngFinish) begin
      if (bsel_q) buf_b_q[LsW'(n_q)] <= actv;
      else buf_a_q[LsW'(n_q)] <= actv;
    end
    ov_q <= ov_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlp_pkg::EngIdle;
      layer_q <= '0; nlay_q <= '0; prev_q <= '0; size_q <= '0;
      n_q <= '0; j_q <= '0; base_q <= '0; rd_q <= '0;
      src_in_q <= 1'b0; bsel_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
      acc_q <= '0; ov_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d; nlay_q <= nlay_d; prev_q <= prev_d; size_q <= size_d;
      n_q <= n_d; j_q <= j_d; base_q <= base_d; rd_q <= rd_d;
      src_in_q <= src_in_d; bsel_q <= bsel_d; v1_q <= issue; v2_q <= v2_d;
      acc_q <= acc_d; ov_v_q <= ov_v_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/mlp_forward_pass.sv
// Top level: MLP inference block with front end, engine and memories.
//   channel  dir  beat contents
//   in_if    in   action, weight_index, sample_index, value, last_sample
//   out_if   out  neuron_index, activation, last_output
//   cfg_if   in   register index, write data
// Weight and sample beats are taken one per cycle while no evaluation is pending. A
// last sample starts a run: a start step, then per layer one setup step and, per
// neuron, prev MAC reads, a pipeline drain and a write-back, then the output beats
// in turn; the single MAC unit and the weight memory port serialise this work. Input
// stalls until the final beat is loaded into the output register, which holds a
// beat until taken. Reset needs no clearing pass.
`default_nettype none
module mlp_forward_pass #(
  parameter int unsigned MaxInputs    = mlp_pkg::MaxInputs,
  parameter int unsigned MaxLayerSize = mlp_pkg::MaxLayerSize,
  parameter int unsigned MaxLayers    = mlp_pkg::MaxLayers,
  parameter int unsigned WeightDepth  = mlp_pkg::WeightDepth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  mlp_in_if.sink    in_if,
  mlp_out_if.source out_if,
  mlp_cfg_if.sink   cfg_if
);
  localparam int unsigned WaW = $clog2(WeightDepth);
  localparam int unsigned XaW = $clog2(MaxInputs);

  mlp_pkg::cfg_t cfg_q;
  logic w_we, x_we, start, start_take;
  logic [WaW-1:0] w_waddr, w_raddr;
  logic [XaW-1:0] x_waddr, x_raddr;
  logic [15:0] wdata, w_rdata, x_rdata;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{num_inputs: 7'd16, num_layers: 3'd1, layer_size_0: 6'd8,
                 layer_size_1: 6'd8, layer_size_2: 6'd8, layer_size_3: 6'd8,
                 activation_mode: 1'b0};
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        mlp_pkg::RegNumInputs:  cfg_q.num_inputs <= cfg_if.data;
        mlp_pkg::RegNumLayers:  cfg_q.num_layers <= cfg_if.data[2:0];
        mlp_pkg::RegLayerSize0: cfg_q.layer_size_0 <= cfg_if.data[5:0];
        mlp_pkg::RegLayerSize1: cfg_q.layer_size_1 <= cfg_if.data[5:0];
        mlp_pkg::RegLayerSize2: cfg_q.layer_size_2 <= cfg_if.data[5:0];
        mlp_pkg::RegLayerSize3: cfg_q.layer_size_3 <= cfg_if.data[5:0];
        mlp_pkg::RegActMode:    cfg_q.activation_mode <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  mlp_front #(.MaxInputs(MaxInputs), .WeightDepth(WeightDepth)) u_front (
    .clk_i, .rst_ni, .in_if,
    .w_we_o(w_we), .w_waddr_o(w_waddr), .x_we_o(x_we), .x_waddr_o(x_waddr),
    .wdata_o(wdata), .start_o(start), .start_take_i(start_take)
  );

  mlp_ram #(.Width(16), .Depth(WeightDepth)) u_wmem (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  mlp_ram #(.Width(16), .Depth(MaxInputs)) u_xmem (
    .clk_i, .we_i(x_we), .waddr_i(x_waddr), .wdata_i(wdata),
    .raddr_i(x_raddr), .rdata_o(x_rdata)
  );

  mlp_engine #(.MaxInputs(MaxInputs), .MaxLayerSize(MaxLayerSize),
               .MaxLayers(MaxLayers), .WeightDepth(WeightDepth)) u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .start_i(start), .start_take_o(start_take),
    .w_raddr_o(w_raddr), .w_rdata_i(w_rdata), .x_raddr_o(x_raddr),
    .x_rdata_i(x_rdata), .out_if
  );
endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for mlp_forward_pass: runs load and evaluate sequences and checks each beat.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 40000;
  localparam int SettleCycles = 20;
  localparam int ItemTarget = 400;
  localparam logic [mlp_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mlp_in_if  in_if ();
  mlp_out_if out_if ();
  mlp_cfg_if cfg_if ();

  mlp_forward_pass i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Network state as the block should hold it.
  logic signed [15:0] weights [mlp_pkg::WeightDepth];
  bit                 weight_set [mlp_pkg::WeightDepth];
  logic signed [15:0] samples [mlp_pkg::MaxInputs];
  bit                 sample_set [mlp_pkg::MaxInputs];
  logic [15:0]        sig_lut [256];
  logic [6:0]         cur_inputs;
  logic [2:0]         cur_layers;
  logic [5:0]         cur_size [mlp_pkg::SizeRegs];
  logic               cur_relu;

  mlp_pkg::out_item_t expected_neurons [$];
  int  errors;
  int  hold_req;
  int  beats_sent;
  bit  no_gaps;

  function automatic int clamp_int(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void build_sig_lut();
    bit [63:0] e;
    bit [63:0] d;
    bit [63:0] v;
    e = 64'd1 << 32;
    sig_lut[128] = 16'd2048;
    for (int k = 1; k <= 128; k++) begin
      e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
      d = (64'd1 << 32) + e;
      v = (64'd4096 * e + d / 2) / d;
      sig_lut[128 - k] = v[15:0];
      if (k < 128) sig_lut[128 + k] = 16'd4096 - v[15:0];
    end
  endfunction

  function automatic int eff_inputs();
    return clamp_int(int'(cur_inputs), 1, mlp_pkg::MaxInputs);
  endfunction

  function automatic int eff_layers();
    return clamp_int(int'(cur_layers), 1, mlp_pkg::SizeRegs);
  endfunction

  function automatic int eff_size(int l);
    return clamp_int(int'(cur_size[l]), 1, mlp_pkg::MaxLayerSize);
  endfunction

  function automatic int weights_needed();
    int prev;
    int total;
    prev = eff_inputs();
    total = 0;
    for (int l = 0; l < eff_layers(); l++) begin
      total += eff_size(l) * prev;
      prev = eff_size(l);
    end
    return total;
  endfunction

  // Walk all layers and queue the final layer's neurons.
  function automatic void predict_layers();
    logic signed [15:0] src [mlp_pkg::MaxInputs];
    logic signed [15:0] dst [mlp_pkg::MaxLayerSize];
    longint acc;
    longint q;
    int prev;
    int sz;
    int off;
    mlp_pkg::out_item_t beat;
    prev = eff_inputs();
    off = 0;
    for (int j = 0; j < mlp_pkg::MaxInputs; j++) src[j] = samples[j];
    for (int l = 0; l < eff_layers(); l++) begin
      sz = eff_size(l);
      for (int n = 0; n < sz; n++) begin
        acc = 0;
        for (int j = 0; j < prev; j++)
          acc += longint'(weights[(off + n * prev + j) % mlp_pkg::WeightDepth]) *
                 longint'(src[j]);
        q = acc >>> 12;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        if (cur_relu) dst[n] = (q <= 0) ? 16'sd0 : 16'(q);
        else dst[n] = sig_lut[(q + 32768) >> 8];
      end
      off += sz * prev;
      for (int n = 0; n < sz; n++) src[n] = dst[n];
      prev = sz;
    end
    for (int n = 0; n < prev; n++) begin
      beat.neuron_index = 5'(n);
      beat.activation = src[n];
      beat.last_output = (n == prev - 1);
      expected_neurons.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_beat(input logic act, input int widx, input int sidx,
                           input logic signed [15:0] val, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= '{action: act, weight_index: 12'(widx), sample_index: 6'(sidx),
                       value: val, last_sample: last};
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
    if (act == mlp_pkg::ActWeight) begin
      weights[widx] = val;
      weight_set[widx] = 1'b1;
    end else begin
      samples[sidx] = val;
      sample_set[sidx] = 1'b1;
      if (last) predict_layers();
    end
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
  endtask

  task automatic cfg_write(input logic [mlp_pkg::CfgIdxW-1:0] idx, input int data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= 7'(data);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      mlp_pkg::RegNumInputs:  cur_inputs = 7'(data);
      mlp_pkg::RegNumLayers:  cur_layers = 3'(data);
      mlp_pkg::RegLayerSize0: cur_size[0] = 6'(data);
      mlp_pkg::RegLayerSize1: cur_size[1] = 6'(data);
      mlp_pkg::RegLayerSize2: cur_size[2] = 6'(data);
      mlp_pkg::RegLayerSize3: cur_size[3] = 6'(data);
      mlp_pkg::RegActMode:    cur_relu = 1'(data);
      default: ;
    endcase
  endtask

  task automatic set_network(input int ni, input int nl, input int s0, input int s1,
                             input int s2, input int s3, input int relu);
    cfg_write(mlp_pkg::RegNumInputs, ni);
    cfg_write(mlp_pkg::RegNumLayers, nl);
    cfg_write(mlp_pkg::RegLayerSize0, s0);
    cfg_write(mlp_pkg::RegLayerSize1, s1);
    cfg_write(mlp_pkg::RegLayerSize2, s2);
    cfg_write(mlp_pkg::RegLayerSize3, s3);
    cfg_write(mlp_pkg::RegActMode, relu);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_neurons.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_value();
    if ($urandom_range(0, 2) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8191) - 4096);
  endfunction

  // Write every weight and sample the next evaluation will read that is not yet set.
  task automatic fill_missing();
    int total;
    int a;
    total = weights_needed();
    for (int i = 0; i < total; i++) begin
      a = i % mlp_pkg::WeightDepth;
      if (!weight_set[a])
        send_beat(mlp_pkg::ActWeight, a, 0, rand_value(), $urandom_range(0, 1));
    end
    for (int j = 0; j < eff_inputs(); j++)
      if (!sample_set[j]) send_beat(mlp_pkg::ActSample, 0, j, rand_value(), 1'b0);
  endtask

  task automatic evaluate(input int sidx, input logic signed [15:0] val);
    fill_missing();
    send_beat(mlp_pkg::ActSample, 0, sidx, val, 1'b1);
  endtask

  task automatic test_reset_defaults();
    evaluate(15, 16'sh7fff);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    set_network(2, 1, 4, 1, 1, 1, 1);
    send_beat(mlp_pkg::ActWeight, 4095, 0, -16'sd32768, 1'b1);
    send_beat(mlp_pkg::ActWeight, 0, 63, 16'sh7fff, 1'b0);
    send_beat(mlp_pkg::ActWeight, 1, 0, -16'sd32768, 1'b0);
    send_beat(mlp_pkg::ActSample, 0, 63, -16'sd32768, 1'b0);
    send_beat(mlp_pkg::ActSample, 0, 0, 16'sh7fff, 1'b0);
    evaluate(1, -16'sd32768);
    wait_drained();
    cfg_write(mlp_pkg::RegActMode, 0);
    evaluate(1, 16'sh7fff);
    evaluate(1, 16'sd0);
    wait_drained();
  endtask

  task automatic test_register_clamping();
    set_network(0, 0, 0, 5, 5, 5, 0);
    evaluate(0, rand_value());
    wait_drained();
    set_network(127, 7, 1, 1, 1, 1, 1);
    evaluate(63, rand_value());
    wait_drained();
    set_network(1, 7, 63, 1, 1, 63, 1);
    cfg_write(RegUnused, 'h55);
    evaluate(0, rand_value());
    wait_drained();
    set_network(3, 4, 2, 3, 4, 2, 0);
    evaluate(10, rand_value());
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_network(4, 2, 3, 32, 1, 1, 1);
    fill_missing();
    wait_drained();
    hold_req = 400;
    send_beat(mlp_pkg::ActSample, 0, 2, rand_value(), 1'b1);
    send_beat(mlp_pkg::ActSample, 0, 1, rand_value(), 1'b0);
    send_beat(mlp_pkg::ActSample, 0, 3, rand_value(), 1'b1);
    wait_drained();
    no_gaps = 1'b1;
    evaluate(0, rand_value());
    evaluate(1, rand_value());
    wait_drained();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_sequences();
    int extra;
    int ni;
    while (beats_sent < ItemTarget) begin
      if ($urandom_range(0, 9) == 0)
        ni = $urandom_range(0, 127);
      else
        ni = $urandom_range(1, 8);
      set_network(ni, $urandom_range(0, 7), $urandom_range(0, 6), $urandom_range(0, 6),
                  $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      extra = $urandom_range(2, 12);
      for (int i = 0; i < extra; i++) begin
        if ($urandom_range(0, 1) == 0)
          send_beat(mlp_pkg::ActWeight,
                    $urandom_range(0, weights_needed() + 20) % mlp_pkg::WeightDepth, 0,
                    rand_value(), $urandom_range(0, 1));
        else
          send_beat(mlp_pkg::ActSample, 0, $urandom_range(0, 63), rand_value(), 1'b0);
      end
      fill_missing();
      send_beat(mlp_pkg::ActSample, 0, $urandom_range(0, 63), rand_value(), 1'b1);
      if ($urandom_range(0, 1) == 0)
        send_beat(mlp_pkg::ActSample, 0, $urandom_range(0, eff_inputs() - 1),
                  rand_value(), 1'b1);
      wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  // Result receiver: random stalls per beat, long hold-off on request.
  initial begin
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 14);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk_i) begin
    mlp_pkg::out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_neurons.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %p", out_if.payload));
      end else begin
        want = expected_neurons.pop_front();
        if (out_if.payload.neuron_index !== want.neuron_index)
          report_mismatch($sformatf("neuron_index %0d, want %0d",
                                    out_if.payload.neuron_index, want.neuron_index));
        if (out_if.payload.activation !== want.activation)
          report_mismatch($sformatf("neuron %0d activation %0d, want %0d",
                                    want.neuron_index, out_if.payload.activation,
                                    want.activation));
        if (out_if.payload.last_output !== want.last_output)
          report_mismatch($sformatf("neuron %0d last_output %0b, want %0b",
                                    want.neuron_index, out_if.payload.last_output,
                                    want.last_output));
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    int quiet;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    errors = 0;
    hold_req = 0;
    beats_sent = 0;
    no_gaps = 1'b0;
    cur_inputs = 7'd16;
    cur_layers = 3'd1;
    for (int l = 0; l < mlp_pkg::SizeRegs; l++) cur_size[l] = 6'd8;
    cur_relu = 1'b0;
    for (int a = 0; a < mlp_pkg::WeightDepth; a++) begin
      weights[a] = '0;
      weight_set[a] = 1'b0;
    end
    for (int j = 0; j < mlp_pkg::MaxInputs; j++) begin
      samples[j] = '0;
      sample_set[j] = 1'b0;
    end
    build_sig_lut();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_register_clamping();
    test_backpressure();
    test_random_sequences();

    wait_drained();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
